// ===== design/vector_to_yaw_pitch_unit_defines.svh =====
// Assertion macros for the vector to yaw/pitch unit.
`ifndef VECTOR_TO_YAW_PITCH_UNIT_DEFINES_SVH
`define VECTOR_TO_YAW_PITCH_UNIT_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define VTYP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition that holds on every rising edge outside reset.
`define VTYP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

`endif

// ===== design/vtyp_pkg.sv =====
// Shared constants, types and the arctangent table of the vector to yaw/pitch unit.
package vtyp_pkg;

  localparam int COORD_BITS    = 24;
  localparam int CORDIC_STAGES = 20;
  localparam int GUARD_SHIFT   = 41 - COORD_BITS;

  localparam int CW      = 44;
  localparam int AW      = 32;
  localparam int RW      = AW - 13;
  localparam int STAGE_W = 5;
  localparam int YAW_W   = 16;
  localparam int PITCH_W = 17;

  localparam int GAIN_W = 20;
  localparam int MAG_W  = CW - 1;
  localparam int LO_W   = 21;
  localparam int HI_W   = MAG_W - LO_W;
  localparam int PROD_W = MAG_W + GAIN_W;

  localparam int LATENCY = 2 * CORDIC_STAGES + 4;

  localparam logic [GAIN_W-1:0]   INV_GAIN      = 20'd636751;
  localparam logic signed [AW-1:0] HALF_TURN_ANG = 32'sd188743680;
  localparam logic signed [AW-1:0] ROUND_BIAS    = 32'sd4096;
  localparam logic signed [RW-1:0] FULL_TURN     = 19'sd46080;
  localparam logic signed [RW-1:0] QUARTER_TURN  = 19'sd11520;
  localparam logic signed [RW-1:0] THREE_QUARTER = 19'sd34560;

  typedef struct packed {
    logic [CW-1:0] z;
    logic [AW-1:0] ang;
    logic          hz;
    logic          xzero;
    logic          ypos;
    logic          zpos;
  } side_t;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [AW-1:0] ang;
    side_t         side;
  } cordic_t;

  // atan(2^-i) in 2^-20 degree
  function automatic logic [AW-1:0] atan_entry(input logic [STAGE_W-1:0] idx);
    logic [AW-1:0] v;
    case (idx)
      5'd0:    v = 32'd47185920;
      5'd1:    v = 32'd27855475;
      5'd2:    v = 32'd14718068;
      5'd3:    v = 32'd7471121;
      5'd4:    v = 32'd3750058;
      5'd5:    v = 32'd1876857;
      5'd6:    v = 32'd938658;
      5'd7:    v = 32'd469357;
      5'd8:    v = 32'd234682;
      5'd9:    v = 32'd117342;
      5'd10:   v = 32'd58671;
      5'd11:   v = 32'd29335;
      5'd12:   v = 32'd14668;
      5'd13:   v = 32'd7334;
      5'd14:   v = 32'd3667;
      5'd15:   v = 32'd1833;
      5'd16:   v = 32'd917;
      5'd17:   v = 32'd458;
      5'd18:   v = 32'd229;
      5'd19:   v = 32'd115;
      5'd20:   v = 32'd57;
      5'd21:   v = 32'd29;
      5'd22:   v = 32'd14;
      5'd23:   v = 32'd7;
      5'd24:   v = 32'd4;
      5'd25:   v = 32'd2;
      5'd26:   v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/vector_to_yaw_pitch_unit.sv =====
// Pipeline from the start transfer to result_strobe: input register,
// 20 yaw CORDIC cells, 2 gain stages, 20 pitch CORDIC cells, result register.
// Throughput: one vector per cycle; busy is always low, every cell moves each cycle.
// Synchronous active-high reset clears the valid chain; data registers are not reset.
// Results are presented for one cycle only; the receiver cannot stall the pipeline.
`include "vector_to_yaw_pitch_unit_defines.svh"

module vector_to_yaw_pitch_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [vtyp_pkg::COORD_BITS-1:0] vec_x,
  input  logic signed [vtyp_pkg::COORD_BITS-1:0] vec_y,
  input  logic signed [vtyp_pkg::COORD_BITS-1:0] vec_z,
  output logic                                   result_strobe,
  output logic signed [vtyp_pkg::PITCH_W-1:0]    pitch_deg,
  output logic [vtyp_pkg::YAW_W-1:0]             yaw_deg
);

  localparam int PAD_W = vtyp_pkg::CW - vtyp_pkg::COORD_BITS - vtyp_pkg::GUARD_SHIFT;

  logic signed [vtyp_pkg::CW-1:0] xs, ys, zs;
  vtyp_pkg::cordic_t              prep_next;
  logic                           accept;

  logic [vtyp_pkg::CORDIC_STAGES:0] yaw_valid;
  vtyp_pkg::cordic_t                yaw_data [0:vtyp_pkg::CORDIC_STAGES];
  logic [vtyp_pkg::CORDIC_STAGES:0] pitch_valid;
  vtyp_pkg::cordic_t                pitch_data [0:vtyp_pkg::CORDIC_STAGES];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    xs = {{PAD_W{vec_x[vtyp_pkg::COORD_BITS-1]}}, vec_x, {vtyp_pkg::GUARD_SHIFT{1'b0}}};
    ys = {{PAD_W{vec_y[vtyp_pkg::COORD_BITS-1]}}, vec_y, {vtyp_pkg::GUARD_SHIFT{1'b0}}};
    zs = {{PAD_W{vec_z[vtyp_pkg::COORD_BITS-1]}}, vec_z, {vtyp_pkg::GUARD_SHIFT{1'b0}}};
    prep_next            = '0;
    prep_next.side.z     = zs;
    prep_next.side.hz    = (xs == '0) && (ys == '0);
    prep_next.side.xzero = (xs == '0);
    prep_next.side.ypos  = (ys > 0);
    prep_next.side.zpos  = (zs > 0);
    // left half-plane: rotate by a half turn first
    if (xs < 0) begin
      prep_next.x   = -xs;
      prep_next.y   = -ys;
      prep_next.ang = (ys >= 0) ? vtyp_pkg::HALF_TURN_ANG : -vtyp_pkg::HALF_TURN_ANG;
    end else begin
      prep_next.x   = xs;
      prep_next.y   = ys;
      prep_next.ang = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_valid[0] <= 1'b0;
    end else begin
      yaw_valid[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    yaw_data[0] <= prep_next;
  end

  for (genvar g = 0; g < vtyp_pkg::CORDIC_STAGES; g++) begin : g_yaw
    vtyp_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage     (vtyp_pkg::STAGE_W'(g)),
      .in_valid  (yaw_valid[g]),
      .in_data   (yaw_data[g]),
      .out_valid (yaw_valid[g+1]),
      .out_data  (yaw_data[g+1])
    );
  end

  vtyp_gain u_gain (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (yaw_valid[vtyp_pkg::CORDIC_STAGES]),
    .in_data   (yaw_data[vtyp_pkg::CORDIC_STAGES]),
    .out_valid (pitch_valid[0]),
    .out_data  (pitch_data[0])
  );

  for (genvar g = 0; g < vtyp_pkg::CORDIC_STAGES; g++) begin : g_pitch
    vtyp_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage     (vtyp_pkg::STAGE_W'(g)),
      .in_valid  (pitch_valid[g]),
      .in_data   (pitch_data[g]),
      .out_valid (pitch_valid[g+1]),
      .out_data  (pitch_data[g+1])
    );
  end

  vtyp_out u_out (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (pitch_valid[vtyp_pkg::CORDIC_STAGES]),
    .in_data       (pitch_data[vtyp_pkg::CORDIC_STAGES]),
    .result_strobe (result_strobe),
    .pitch_deg     (pitch_deg),
    .yaw_deg       (yaw_deg)
  );

  `VTYP_ASSERT_IMP(a_yaw_range, result_strobe, yaw_deg < 16'd46080, "yaw out of range")
  `VTYP_ASSERT_IMP(a_pitch_range, result_strobe, (pitch_deg <= 0) && (pitch_deg > -17'sd46080), "pitch out of range")
  `VTYP_ASSERT_IMP(a_strobe_origin, result_strobe, $past(start, vtyp_pkg::LATENCY), "result without transfer")
  `VTYP_ASSERT_IMP(a_gain_x_sign, yaw_valid[vtyp_pkg::CORDIC_STAGES], !yaw_data[vtyp_pkg::CORDIC_STAGES].x[vtyp_pkg::CW-1], "negative length into gain stage")

endmodule

// ===== design/vtyp_cell.sv =====
// One registered CORDIC vectoring iteration.
module vtyp_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [vtyp_pkg::STAGE_W-1:0]  stage,
  input  logic                          in_valid,
  input  vtyp_pkg::cordic_t             in_data,
  output logic                          out_valid,
  output vtyp_pkg::cordic_t             out_data
);

  logic signed [vtyp_pkg::CW-1:0] x, y, dx, dy;
  logic signed [vtyp_pkg::AW-1:0] a, da;
  vtyp_pkg::cordic_t              data_next;

  always_comb begin
    x  = $signed(in_data.x);
    y  = $signed(in_data.y);
    a  = $signed(in_data.ang);
    dx = y >>> stage;
    dy = x >>> stage;
    da = $signed(vtyp_pkg::atan_entry(stage));
    data_next = in_data;
    if (!y[vtyp_pkg::CW-1]) begin
      data_next.x   = x + dx;
      data_next.y   = y - dy;
      data_next.ang = a + da;
    end else begin
      data_next.x   = x - dx;
      data_next.y   = y + dy;
      data_next.ang = a - da;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

// ===== design/vtyp_gain.sv =====
// Gain compensation of the horizontal length, two partial products over two stages.
module vtyp_gain (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  vtyp_pkg::cordic_t in_data,
  output logic              out_valid,
  output vtyp_pkg::cordic_t out_data
);

  logic [vtyp_pkg::LO_W-1:0]                   mag_lo;
  logic [vtyp_pkg::HI_W-1:0]                   mag_hi;
  logic [vtyp_pkg::LO_W+vtyp_pkg::GAIN_W-1:0]  prod_lo;
  logic [vtyp_pkg::HI_W+vtyp_pkg::GAIN_W-1:0]  prod_hi;
  vtyp_pkg::side_t                             side_in;
  vtyp_pkg::side_t                             side;
  logic                                        mid_valid;
  logic [vtyp_pkg::PROD_W-1:0]                 sum;
  vtyp_pkg::cordic_t                           data_next;

  // x is never negative after the yaw rotations
  assign mag_lo = in_data.x[vtyp_pkg::LO_W-1:0];
  assign mag_hi = in_data.x[vtyp_pkg::MAG_W-1:vtyp_pkg::LO_W];

  // yaw angle rides along in the side data
  always_comb begin
    side_in     = in_data.side;
    side_in.ang = in_data.ang;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mid_valid <= in_valid;
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_lo  <= mag_lo * vtyp_pkg::INV_GAIN;
    prod_hi  <= mag_hi * vtyp_pkg::INV_GAIN;
    side     <= side_in;
    out_data <= data_next;
  end

  always_comb begin
    sum = {prod_hi, {vtyp_pkg::LO_W{1'b0}}} + {{vtyp_pkg::HI_W{1'b0}}, prod_lo};
    data_next      = '0;
    data_next.x    = {1'b0, sum[vtyp_pkg::PROD_W-1:vtyp_pkg::GAIN_W]};
    data_next.y    = side.z;
    data_next.ang  = '0;
    data_next.side = side;
  end

endmodule

// ===== design/vtyp_out.sv =====
// Rounding, wrapping and special cases of the two angles into the result registers.
module vtyp_out (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  vtyp_pkg::cordic_t                   in_data,
  output logic                                result_strobe,
  output logic signed [vtyp_pkg::PITCH_W-1:0] pitch_deg,
  output logic [vtyp_pkg::YAW_W-1:0]          yaw_deg
);

  logic signed [vtyp_pkg::AW-1:0] yaw_biased, pitch_biased;
  logic signed [vtyp_pkg::RW-1:0] yaw_r, pitch_r, yaw_next, pitch_next, pitch_neg;

  always_comb begin
    yaw_biased   = $signed(in_data.side.ang) + vtyp_pkg::ROUND_BIAS;
    pitch_biased = $signed(in_data.ang) + vtyp_pkg::ROUND_BIAS;
    yaw_r        = yaw_biased[vtyp_pkg::AW-1:13];
    pitch_r      = pitch_biased[vtyp_pkg::AW-1:13];

    if (in_data.side.hz) begin
      yaw_next = '0;
    end else if (in_data.side.xzero) begin
      yaw_next = in_data.side.ypos ? vtyp_pkg::QUARTER_TURN : vtyp_pkg::THREE_QUARTER;
    end else if (yaw_r < 0) begin
      yaw_next = yaw_r + vtyp_pkg::FULL_TURN;
    end else if (yaw_r >= vtyp_pkg::FULL_TURN) begin
      yaw_next = yaw_r - vtyp_pkg::FULL_TURN;
    end else begin
      yaw_next = yaw_r;
    end

    if (in_data.side.hz) begin
      pitch_next = in_data.side.zpos ? vtyp_pkg::QUARTER_TURN : vtyp_pkg::THREE_QUARTER;
    end else if (pitch_r < 0) begin
      pitch_next = pitch_r + vtyp_pkg::FULL_TURN;
    end else begin
      pitch_next = pitch_r;
    end
    pitch_neg = -pitch_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    yaw_deg   <= yaw_next[vtyp_pkg::YAW_W-1:0];
    pitch_deg <= pitch_neg[vtyp_pkg::PITCH_W-1:0];
  end

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for vector_to_yaw_pitch_unit: directed and random vectors.
`timescale 1ns / 100ps

module testbench;

  localparam int CLK_PERIOD   = 4;
  localparam int PIPE_DEPTH   = 44;
  localparam int STAGES       = 20;
  localparam int GUARD        = 41 - vtyp_pkg::COORD_BITS;
  localparam int RUN_LIMIT_NS = 2000000;

  localparam longint INV_GAIN_Q20  = 636751;
  localparam longint HALF_TURN_Q20 = 64'sd188743680;
  localparam longint FULL_UNITS    = 46080;
  localparam longint QUARTER_UNITS = 11520;
  localparam longint THREE_Q_UNITS = 34560;

  typedef logic signed [vtyp_pkg::COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic signed [vtyp_pkg::PITCH_W-1:0] pitch;
    logic [vtyp_pkg::YAW_W-1:0]          yaw;
  } angles_t;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] ang;
  } rotation_t;

  localparam coord_t COORD_MAX = 24'sh7fffff;
  localparam coord_t COORD_MIN = 24'sh800000;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  coord_t vec_x, vec_y, vec_z;
  logic result_strobe;
  logic signed [vtyp_pkg::PITCH_W-1:0] pitch_deg;
  logic [vtyp_pkg::YAW_W-1:0] yaw_deg;

  // atan(2^-i) in 2^-20 degree
  longint arctan_q20 [0:STAGES-1] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115
  };

  angles_t expected_angles [$];
  int fault_count = 0;

  vector_to_yaw_pitch_unit dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .vec_x         (vec_x),
    .vec_y         (vec_y),
    .vec_z         (vec_z),
    .result_strobe (result_strobe),
    .pitch_deg     (pitch_deg),
    .yaw_deg       (yaw_deg)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Drives y towards zero; shifts floor, as arithmetic shifts do.
  function automatic rotation_t rotate_to_axis(longint x, longint y);
    rotation_t r;
    longint dx, dy, ang;
    ang = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        ang = ang + arctan_q20[i];
      end else begin
        x = x - dx;
        y = y + dy;
        ang = ang - arctan_q20[i];
      end
    end
    r.x = x;
    r.y = y;
    r.ang = ang;
    return r;
  endfunction

  function automatic longint to_units(longint ang);
    return (ang + 4096) >>> 13;
  endfunction

  function automatic angles_t predict_angles(coord_t vx, coord_t vy, coord_t vz);
    angles_t res;
    longint x, y, z, base, yaw, pitch, horiz, ang;
    rotation_t yaw_pass, pitch_pass;
    x = longint'(vx) <<< GUARD;
    y = longint'(vy) <<< GUARD;
    z = longint'(vz) <<< GUARD;
    if (x == 0 && y == 0) begin
      yaw = 0;
      pitch = (z > 0) ? QUARTER_UNITS : THREE_Q_UNITS;
    end else begin
      base = 0;
      if (x < 0) begin
        base = (y >= 0) ? HALF_TURN_Q20 : -HALF_TURN_Q20;
        x = -x;
        y = -y;
      end
      yaw_pass = rotate_to_axis(x, y);
      ang = yaw_pass.ang;
      if (vx == 0) begin
        yaw = (vy > 0) ? QUARTER_UNITS : THREE_Q_UNITS;
      end else begin
        yaw = to_units(base + ang);
        if (yaw < 0) yaw = yaw + FULL_UNITS;
        if (yaw >= FULL_UNITS) yaw = yaw - FULL_UNITS;
      end
      horiz = yaw_pass.x;
      horiz = (horiz * INV_GAIN_Q20) >>> 20;
      pitch_pass = rotate_to_axis(horiz, z);
      ang = pitch_pass.ang;
      pitch = to_units(ang);
      if (pitch < 0) pitch = pitch + FULL_UNITS;
    end
    res.pitch = vtyp_pkg::PITCH_W'(-pitch);
    res.yaw = vtyp_pkg::YAW_W'(yaw);
    return res;
  endfunction

  function automatic coord_t pick_coord();
    coord_t raw;
    raw = coord_t'($urandom);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return raw >>> $urandom_range(12, 23);
      2: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      3, 4: return raw >>> $urandom_range(1, 11);
      default: return raw;
    endcase
  endfunction

  // transfer completes at the edge where busy is low
  task automatic send_vector(input coord_t x, input coord_t y, input coord_t z);
    start <= 1'b1;
    vec_x <= x;
    vec_y <= y;
    vec_z <= z;
    do @(posedge clk); while (busy === 1'b1);
    expected_angles.push_back(predict_angles(x, y, z));
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic test_zero_horizontal();
    send_vector(0, 0, 0);
    send_vector(0, 0, 1);
    send_vector(0, 0, -1);
    send_vector(0, 0, COORD_MAX);
    send_vector(0, 0, COORD_MIN);
  endtask

  task automatic test_axis_directions();
    send_vector(0, 1, 0);
    send_vector(0, -1, 5);
    send_vector(0, COORD_MAX, COORD_MIN);
    send_vector(0, COORD_MIN, COORD_MAX);
    send_vector(COORD_MAX, 0, 0);
    send_vector(COORD_MIN, 0, 0);
  endtask

  task automatic test_field_extremes();
    send_vector(COORD_MAX, COORD_MAX, COORD_MAX);
    send_vector(COORD_MIN, COORD_MIN, COORD_MIN);
    send_vector(COORD_MIN, COORD_MAX, 0);
    send_vector(COORD_MAX, COORD_MIN, -1);
    send_vector(1, -1, 1);
    send_vector(-1, 1, -1);
  endtask

  // yaw just below a full turn, yaw either side of the half turn, pitch just below zero
  task automatic test_rounding_wraps();
    send_vector(COORD_MAX, -1144, 0);
    send_vector(COORD_MIN, -1, 0);
    send_vector(COORD_MIN, 1, 0);
    send_vector(COORD_MAX, 0, -1);
    send_vector(COORD_MAX, 0, -1144);
  endtask

  task automatic test_random_vectors(input int total);
    int sent, burst;
    sent = 0;
    while (sent < total) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < total; k++) begin
        send_vector(pick_coord(), pick_coord(), pick_coord());
        sent++;
      end
      pause_sender($urandom_range(1, 50));
    end
  endtask

  always @(posedge clk) begin : result_check
    angles_t want;
    if (rst === 1'b0 && result_strobe === 1'b1) begin
      if (expected_angles.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("%0t: unexpected result: pitch %0d yaw %0d", $time, pitch_deg, yaw_deg);
      end else begin
        want = expected_angles.pop_front();
        if (pitch_deg !== want.pitch || yaw_deg !== want.yaw) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: mismatch: pitch exp %0d got %0d, yaw exp %0d got %0d",
                     $time, want.pitch, pitch_deg, want.yaw, yaw_deg);
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    vec_x <= '0;
    vec_y <= '0;
    vec_z <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_zero_horizontal();
    pause_sender(3);
    test_axis_directions();
    pause_sender(17);
    test_field_extremes();
    pause_sender(1);
    test_rounding_wraps();
    pause_sender(40);
    test_random_vectors(1550);
    start <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (fault_count == 0 && expected_angles.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
